// ===== rtl/core/abst_pkg.sv =====
`timescale 1ns / 1ps

package abst_pkg;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned OUT_IDX_W = 10;

  localparam logic [KEY_W-1:0] KEY_EMPTY = '0;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;  // sweep one store entry to empty
    logic load;   // capture the request beat
    logic walk;   // evaluate one tree level
    logic emit;   // move the finished result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/abst_if.sv =====
`timescale 1ns / 1ps

interface abst_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [abst_pkg::KEY_W-1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface abst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          found;
  logic [abst_pkg::OUT_IDX_W-1:0] node_index;

  modport source (output valid, output status, output found, output node_index, input ready);
  modport sink   (input valid, input status, input found, input node_index, output ready);
endinterface

// ===== rtl/core/abst_ctrl.sv =====
`timescale 1ns / 1ps

module abst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  abst_pkg::sts_t sts_i,
  output abst_pkg::cmd_t cmd_o
);

  abst_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abst_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      abst_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = abst_pkg::ST_IDLE;
        end
      end
      abst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = abst_pkg::ST_WALK;
        end
      end
      abst_pkg::ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_end) begin
          state_d = abst_pkg::ST_DONE;
        end
      end
      abst_pkg::ST_DONE: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = abst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = abst_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/abst_dpath.sv =====
`timescale 1ns / 1ps

module abst_dpath #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  abst_pkg::cmd_t                 cmd_i,
  output abst_pkg::sts_t                 sts_o,
  input  logic                           in_func_i,
  input  logic [abst_pkg::KEY_W-1:0]     in_key_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_status_o,
  output logic                           out_found_o,
  output logic [abst_pkg::OUT_IDX_W-1:0] out_node_index_o
);

  localparam int unsigned IDX_W  = $clog2(NODE_COUNT);
  // walk index reaches 2*NODE_COUNT at most
  localparam int unsigned WALK_W = IDX_W + 2;
  localparam logic [WALK_W-1:0] WALK_LIMIT = WALK_W'(NODE_COUNT);
  localparam logic [IDX_W-1:0]  CLR_LAST   = IDX_W'(NODE_COUNT - 1);

  logic [abst_pkg::KEY_W-1:0] mem [NODE_COUNT];
  logic [abst_pkg::KEY_W-1:0] rdata_q;

  logic                       func_q;
  logic [abst_pkg::KEY_W-1:0] key_q;
  logic [WALK_W-1:0]          idx_q, idx_d, idx_next;
  logic [IDX_W-1:0]           clr_q, clr_d;

  logic                           res_status_q, res_status_d;
  logic                           res_found_q, res_found_d;
  logic [abst_pkg::OUT_IDX_W-1:0] res_idx_q, res_idx_d;

  logic                           out_v_q, out_v_d;
  logic                           out_status_q;
  logic                           out_found_q;
  logic [abst_pkg::OUT_IDX_W-1:0] out_idx_q;

  logic in_range, slot_empty, key_zero, key_hit, walk_end, wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [abst_pkg::KEY_W-1:0] wr_data;

  assign in_range   = idx_q < WALK_LIMIT;
  assign slot_empty = rdata_q == abst_pkg::KEY_EMPTY;
  assign key_zero   = key_q == abst_pkg::KEY_EMPTY;
  assign key_hit    = rdata_q == key_q;
  assign walk_end   = key_zero || !in_range || slot_empty ||
                      (func_q == abst_pkg::FUNC_SEARCH && key_hit);

  assign idx_next = (key_q <= rdata_q) ? ({idx_q[WALK_W-2:0], 1'b0} + WALK_W'(1))
                                       : ({idx_q[WALK_W-2:0], 1'b0} + WALK_W'(2));
  // read ahead at the next level's index; return to the root when not walking
  assign idx_d = (cmd_i.walk && !walk_end) ? idx_next
               : (cmd_i.walk ? idx_q : '0);

  always_comb begin
    res_status_d = abst_pkg::STATUS_OK;
    res_found_d  = 1'b0;
    res_idx_d    = '0;
    if (key_zero) begin
      res_status_d = abst_pkg::STATUS_OK;
    end else if (!in_range) begin
      res_status_d = (func_q == abst_pkg::FUNC_INSERT) ? abst_pkg::STATUS_NO_ROOM
                                                       : abst_pkg::STATUS_OK;
    end else if (func_q == abst_pkg::FUNC_INSERT) begin
      res_idx_d = abst_pkg::OUT_IDX_W'(idx_q);
    end else if (key_hit) begin
      res_found_d = 1'b1;
      res_idx_d   = abst_pkg::OUT_IDX_W'(idx_q);
    end
  end

  assign wr_en   = cmd_i.clear ||
                   (cmd_i.walk && func_q == abst_pkg::FUNC_INSERT && !key_zero &&
                    in_range && slot_empty);
  assign wr_addr = cmd_i.clear ? clr_q : idx_q[IDX_W-1:0];
  assign wr_data = cmd_i.clear ? abst_pkg::KEY_EMPTY : key_q;
  assign clr_d   = cmd_i.clear ? (clr_q + IDX_W'(1)) : clr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[idx_d[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      clr_q <= '0;
    end else begin
      idx_q <= idx_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      key_q  <= in_key_i;
    end
    if (cmd_i.walk && walk_end) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_idx_q    <= res_idx_d;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_idx_q    <= res_idx_q;
    end
  end

  assign out_v_d = cmd_i.emit || (out_v_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  assign sts_o.clr_last = clr_q == CLR_LAST;
  assign sts_o.walk_end = walk_end;
  assign sts_o.out_free = !out_v_q || out_ready_i;

  assign out_valid_o      = out_v_q;
  assign out_status_o     = out_status_q;
  assign out_found_o      = out_found_q;
  assign out_node_index_o = out_idx_q;

endmodule

// ===== rtl/core/array_bst_insert_search_core.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Payload                         | Beat
// req_i    | in  | func (1), key (8)               | valid & ready
// rsp_o    | out | status (1), found (1), idx (10) | valid & ready
//
// After reset the node store is swept to empty, one entry per cycle, all
// NODE_COUNT entries (1024 by default), with req_i.ready low.
// One request at a time: the accept, then a walk step per tree level visited
// (a store read per level, at most $clog2(NODE_COUNT+1) levels, 11 for
// 1024 slots), one more step when the path runs past the store, and a last
// step, once it is free, to load the output register; a zero key ends at the root.
// The response sits in an output register, so a stalled rsp_o does not block
// the next request from being accepted and walked.
module array_bst_insert_search_core #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  abst_req_if.sink      req_i,
  abst_rsp_if.source    rsp_o
);

  abst_pkg::cmd_t cmd;
  abst_pkg::sts_t sts;

  abst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abst_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_func_i        (req_i.func),
    .in_key_i         (req_i.key),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .out_status_o     (rsp_o.status),
    .out_found_o      (rsp_o.found),
    .out_node_index_o (rsp_o.node_index)
  );

endmodule

// ===== rtl/core/abst_checker.sv =====
`timescale 1ns / 1ps

module abst_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic                           rsp_status_i,
  input logic                           rsp_found_i,
  input logic [abst_pkg::OUT_IDX_W-1:0] rsp_node_index_i
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_found_i) && $stable(rsp_node_index_i))
    else $error("response beat changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  a_status_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_status_i && rsp_found_i))
    else $error("no-room and found both set");

  a_no_room_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i |-> rsp_node_index_i == '0)
    else $error("no-room response carries a slot index");

endmodule

bind array_bst_insert_search_core abst_checker u_abst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_found_i      (rsp_o.found),
  .rsp_node_index_i (rsp_o.node_index)
);

// ===== bench/bst_walk_checker.sv =====
`timescale 1ns / 1ps

module bst_walk_checker #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  abst_req_if   req_mon,
  abst_rsp_if   rsp_mon,
  output int    fail_count_o,
  output int    pending_o,
  output int    inserts_o,
  output int    full_paths_o,
  output int    searches_o,
  output int    hits_o
);

  typedef struct packed {
    logic                           status;
    logic                           found;
    logic [abst_pkg::OUT_IDX_W-1:0] node_index;
  } bst_answer_t;

  logic [abst_pkg::KEY_W-1:0] tree_slots [NODE_COUNT];
  bst_answer_t                pending_answers [$];

  // Walk the tree for one request and update the shadow store on an insert.
  function automatic bst_answer_t walk_tree(input logic func,
                                            input logic [abst_pkg::KEY_W-1:0] key);
    bst_answer_t ans;
    int unsigned slot;
    bit          busy;
    ans.status     = abst_pkg::STATUS_OK;
    ans.found      = 1'b0;
    ans.node_index = '0;
    slot = 0;
    busy = (key != abst_pkg::KEY_EMPTY);
    while (busy) begin
      if (slot >= NODE_COUNT) begin
        if (func == abst_pkg::FUNC_INSERT) ans.status = abst_pkg::STATUS_NO_ROOM;
        busy = 1'b0;
      end else if (func == abst_pkg::FUNC_INSERT &&
                   tree_slots[slot] == abst_pkg::KEY_EMPTY) begin
        tree_slots[slot] = key;
        ans.node_index   = slot[abst_pkg::OUT_IDX_W-1:0];
        busy             = 1'b0;
      end else if (func == abst_pkg::FUNC_SEARCH && tree_slots[slot] == key) begin
        ans.found      = 1'b1;
        ans.node_index = slot[abst_pkg::OUT_IDX_W-1:0];
        busy           = 1'b0;
      end else if (func == abst_pkg::FUNC_SEARCH &&
                   tree_slots[slot] == abst_pkg::KEY_EMPTY) begin
        busy = 1'b0;
      end else begin
        // equal keys descend left
        slot = (key <= tree_slots[slot]) ? 2 * slot + 1 : 2 * slot + 2;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bst_answer_t want;
    bst_answer_t got;
    if (!rst_ni) begin
      foreach (tree_slots[i]) tree_slots[i] = abst_pkg::KEY_EMPTY;
      pending_answers.delete();
      fail_count_o = 0;
      pending_o    = 0;
      inserts_o    = 0;
      full_paths_o = 0;
      searches_o   = 0;
      hits_o       = 0;
    end else begin
      // retire the response beat first: a request taken at this edge cannot answer at it
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status     = rsp_mon.status;
        got.found      = rsp_mon.found;
        got.node_index = rsp_mon.node_index;
        if (pending_answers.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected response: status=%0b found=%0b index=%0d",
                     got.status, got.found, got.node_index);
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.node_index !== want.node_index) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: expected status=%0b found=%0b index=%0d, ",
                        "got status=%0b found=%0b index=%0d"},
                       want.status, want.found, want.node_index,
                       got.status, got.found, got.node_index);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        want = walk_tree(req_mon.func, req_mon.key);
        pending_answers.push_back(want);
        if (req_mon.func == abst_pkg::FUNC_INSERT) begin
          inserts_o++;
          if (want.status == abst_pkg::STATUS_NO_ROOM) full_paths_o++;
        end else begin
          searches_o++;
          if (want.found) hits_o++;
        end
      end
      pending_o = pending_answers.size();
    end
  end

endmodule

// ===== bench/array_bst_insert_search_core_test.sv =====
`timescale 1ns / 1ps

module array_bst_insert_search_core_test;

  localparam int unsigned NODE_COUNT   = 1024;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned IDLE_LIMIT   = 6000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 30;

  logic clk_i;
  logic rst_ni;

  abst_req_if req_ch ();
  abst_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int inserts;
  int full_paths;
  int searches;
  int hits;
  int sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  logic [abst_pkg::KEY_W-1:0] inserted_keys [$];

  array_bst_insert_search_core #(
    .NODE_COUNT(NODE_COUNT)
  ) dut (
    .clk_i,
    .rst_ni,
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  bst_walk_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .inserts_o    (inserts),
    .full_paths_o (full_paths),
    .searches_o   (searches),
    .hits_o       (hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(input logic func, input logic [abst_pkg::KEY_W-1:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= func;
    req_ch.key   <= key;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
    if (func == abst_pkg::FUNC_INSERT) inserted_keys.push_back(key);
  endtask

  initial begin : stimulus
    logic [abst_pkg::KEY_W-1:0] key;
    logic                       func;
    int                         roll;
    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.func   = abst_pkg::FUNC_INSERT;
    req_ch.key    = abst_pkg::KEY_EMPTY;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key on an empty tree, both operations
    send_beat(abst_pkg::FUNC_SEARCH, abst_pkg::KEY_EMPTY);
    send_beat(abst_pkg::FUNC_INSERT, abst_pkg::KEY_EMPTY);
    send_beat(abst_pkg::FUNC_INSERT, 8'h80);
    // duplicates of the smallest key fill the left spine down to slot 1023, then overflow
    repeat (11) send_beat(abst_pkg::FUNC_INSERT, 8'h01);
    // rising keys fill the right spine down to slot 1022; the last one overflows
    for (int k = 'hF6; k <= 'hFF; k++)
      send_beat(abst_pkg::FUNC_INSERT, k[abst_pkg::KEY_W-1:0]);
    send_beat(abst_pkg::FUNC_SEARCH, 8'hFF);
    send_beat(abst_pkg::FUNC_SEARCH, 8'hFE);
    send_beat(abst_pkg::FUNC_SEARCH, 8'h01);
    send_beat(abst_pkg::FUNC_SEARCH, 8'h80);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet <= (n >= 800 && n < 950);
      roll = $urandom_range(0, 99);
      func = (roll < 50) ? abst_pkg::FUNC_INSERT : abst_pkg::FUNC_SEARCH;
      // bias searches toward keys already sent as inserts
      if (func == abst_pkg::FUNC_SEARCH && roll < 85)
        key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      else
        key = abst_pkg::KEY_W'($urandom_range(0, 255));
      send_beat(func, key);
    end
    req_ch.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts (%0d ran past the store) and %0d searches (%0d hits)",
             inserts, full_paths, searches, hits);
    $display("both tree spines reached their deepest slots; zero keys and a long stall seen");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS array_bst_insert_search_core");
    end else begin
      $display("FAIL array_bst_insert_search_core");
    end
    $finish;
  end

  initial begin : receiver
    int  hold;
    bit  long_done;
    long_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_done && sent >= 500) begin
        // hold off long enough to back up the output register and stall requests
        long_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("FAIL array_bst_insert_search_core");
      $finish;
    end
  end

endmodule
